// ===== rtl/core/tsyn_pkg.sv =====
// Shared types, codes, constants and decay table function for the ternary STDP synapse.
package tsyn_pkg;

  localparam int DECAY_TABLE_DEPTH_DEF  = 256;
  localparam int TIME_FRACTION_BITS_DEF = 4;
  localparam int QUEUE_DEPTH            = 2;

  localparam logic [2:0] OP_PRE    = 3'd0;
  localparam logic [2:0] OP_POST   = 3'd1;
  localparam logic [2:0] OP_PAIR   = 3'd2;
  localparam logic [2:0] OP_REPEAT = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_POT_GAIN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEP_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RISE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REL_POS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REL_NEG  = 3'd5;

  localparam logic [15:0]        POT_GAIN_RST = 16'd1311;
  localparam logic [15:0]        DEP_GAIN_RST = 16'd1638;
  localparam logic signed [15:0] RISE_RST     = 16'sd4096;
  localparam logic signed [15:0] FALL_RST     = -16'sd4096;
  localparam logic signed [15:0] REL_POS_RST  = 16'sd12288;
  localparam logic signed [15:0] REL_NEG_RST  = -16'sd12288;

  localparam logic signed [15:0] PHASE_MAX = 16'sd16384;
  localparam logic signed [15:0] PHASE_MIN = -16'sd16384;
  localparam logic signed [15:0] INIT_HALF = 16'sd8192;

  localparam logic [1:0] W_ZERO = 2'b00;
  localparam logic [1:0] W_POS  = 2'b01;
  localparam logic [1:0] W_NEG  = 2'b11;

  localparam logic [1:0] KIND_NOP    = 2'd0;
  localparam logic [1:0] KIND_INIT   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  localparam logic [63:0] DECAY_RATIO_Q32 = 64'd4085499269;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [32:0] dt;
    logic [15:0]        count;
    logic signed [15:0] start;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        pot_gain;
    logic [15:0]        dep_gain;
    logic signed [15:0] rise;
    logic signed [15:0] fall;
    logic signed [15:0] rel_pos;
    logic signed [15:0] rel_neg;
  } cfg_t;

  // exp(-k/20) in Q1.16, zero past the table; evaluated at elaboration only
  function automatic logic [16:0] decay_entry(input int unsigned k, input int unsigned depth);
    logic [127:0] acc;
    logic [127:0] base;
    logic [127:0] rnd;
    int unsigned  n;
    int           i;
    acc  = 128'd1 << 32;
    base = {64'd0, DECAY_RATIO_Q32};
    rnd  = 128'd1 << 31;
    n    = k;
    if (k >= depth) begin
      return 17'd0;
    end
    for (i = 0; i < 32; i++) begin
      if (n[0]) begin
        acc = (acc * base + rnd) >> 32;
      end
      base = (base * base + rnd) >> 32;
      n = n >> 1;
    end
    acc = (acc + (128'd1 << 15)) >> 16;
    return acc[16:0];
  endfunction

endpackage

// ===== rtl/core/ternary_stdp_synapse_top.sv =====
// Top level of the ternary STDP synapse: configuration registers and unit wiring.
//
// Usage:
//   Input side is a queue: present an event with push; a beat is taken on a
//   rising edge with push high and full low. Result side is a queue too: the
//   oldest result sits on ternary_weight, phase_value and updated while empty
//   is low, and is taken on a rising edge with pop high.
//   Registers are written through cfg_write / cfg_index / cfg_data, one per
//   edge; the user must write them only while no event is in flight, as the
//   block does not enforce this. An event that applies no update (lone spike,
//   initialise, unused code) passes from the queue through the engine's idle
//   and done states; an update event passes idle, ROM lookup, multiply, N
//   apply steps and done, N being 1 for spikes and pairs and pair_count for
//   repeated pairs. The accumulate loop applies one update per cycle. The
//   two-entry command queue lets the front end take events while the engine
//   works.
//   A stalled receiver holds its result; the engine finishes the next event
//   and then waits, and the input fills up and raises full.
//   Reset clears all spike history, phase and weight and loads the default
//   register values; no result is pending after reset.
module ternary_stdp_synapse_top #(
  parameter int DECAY_TABLE_DEPTH  = tsyn_pkg::DECAY_TABLE_DEPTH_DEF,
  parameter int TIME_FRACTION_BITS = tsyn_pkg::TIME_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [2:0]                       operation,
  input  logic [31:0]                      spike_time,
  input  logic [31:0]                      post_time,
  input  logic signed [15:0]               pair_spacing,
  input  logic [15:0]                      pair_count,
  input  logic signed [15:0]               start_value,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [1:0]                ternary_weight,
  output logic signed [15:0]               phase_value,
  output logic                             updated,
  input  logic                             cfg_write,
  input  logic [tsyn_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data
);

  tsyn_pkg::cfg_t cfg;
  tsyn_pkg::cmd_t front_cmd;
  tsyn_pkg::cmd_t q_data;
  logic           front_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pot_gain <= tsyn_pkg::POT_GAIN_RST;
      cfg.dep_gain <= tsyn_pkg::DEP_GAIN_RST;
      cfg.rise     <= tsyn_pkg::RISE_RST;
      cfg.fall     <= tsyn_pkg::FALL_RST;
      cfg.rel_pos  <= tsyn_pkg::REL_POS_RST;
      cfg.rel_neg  <= tsyn_pkg::REL_NEG_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsyn_pkg::REG_POT_GAIN: cfg.pot_gain <= cfg_data;
        tsyn_pkg::REG_DEP_GAIN: cfg.dep_gain <= cfg_data;
        tsyn_pkg::REG_RISE:     cfg.rise     <= $signed(cfg_data);
        tsyn_pkg::REG_FALL:     cfg.fall     <= $signed(cfg_data);
        tsyn_pkg::REG_REL_POS:  cfg.rel_pos  <= $signed(cfg_data);
        tsyn_pkg::REG_REL_NEG:  cfg.rel_neg  <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign full = q_full;

  tsyn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .queue_full   (q_full),
    .operation    (operation),
    .spike_time   (spike_time),
    .post_time    (post_time),
    .pair_spacing (pair_spacing),
    .pair_count   (pair_count),
    .start_value  (start_value),
    .cmd_push     (front_push),
    .cmd          (front_cmd)
  );

  tsyn_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  tsyn_back #(
    .DECAY_TABLE_DEPTH  (DECAY_TABLE_DEPTH),
    .TIME_FRACTION_BITS (TIME_FRACTION_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .ternary_weight (ternary_weight),
    .phase_value    (phase_value),
    .updated        (updated)
  );

endmodule

// ===== rtl/core/tsyn_front.sv =====
// Front end: accepts spike events, keeps spike times and forms update, initialise and no-op commands.
module tsyn_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  queue_full,
  input  logic [2:0]            operation,
  input  logic [31:0]           spike_time,
  input  logic [31:0]           post_time,
  input  logic signed [15:0]    pair_spacing,
  input  logic [15:0]           pair_count,
  input  logic signed [15:0]    start_value,
  output logic                  cmd_push,
  output tsyn_pkg::cmd_t        cmd
);

  logic [31:0]        last_pre_time;
  logic [31:0]        last_post_time;
  logic               pre_seen;
  logic               post_seen;
  logic signed [32:0] op_a;
  logic signed [32:0] op_b;

  assign cmd_push = push && !queue_full;

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    cmd.kind  = tsyn_pkg::KIND_NOP;
    cmd.count = 16'd1;
    cmd.start = start_value;
    unique case (operation)
      tsyn_pkg::OP_PRE: begin
        op_a = {1'b0, last_post_time};
        op_b = {1'b0, spike_time};
        if (post_seen) cmd.kind = tsyn_pkg::KIND_UPDATE;
      end
      tsyn_pkg::OP_POST: begin
        op_a = {1'b0, spike_time};
        op_b = {1'b0, last_pre_time};
        if (pre_seen) cmd.kind = tsyn_pkg::KIND_UPDATE;
      end
      tsyn_pkg::OP_PAIR: begin
        op_a     = {1'b0, post_time};
        op_b     = {1'b0, spike_time};
        cmd.kind = tsyn_pkg::KIND_UPDATE;
      end
      tsyn_pkg::OP_REPEAT: begin
        op_a      = 33'(pair_spacing);
        cmd.count = pair_count;
        if (pair_count != 16'd0) cmd.kind = tsyn_pkg::KIND_UPDATE;
      end
      tsyn_pkg::OP_INIT: begin
        cmd.kind = tsyn_pkg::KIND_INIT;
      end
      default: begin
        cmd.kind = tsyn_pkg::KIND_NOP;
      end
    endcase
    cmd.dt = op_a - op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pre_time  <= '0;
      last_post_time <= '0;
      pre_seen       <= 1'b0;
      post_seen      <= 1'b0;
    end else if (cmd_push) begin
      unique case (operation)
        tsyn_pkg::OP_PRE: begin
          last_pre_time <= spike_time;
          pre_seen      <= 1'b1;
        end
        tsyn_pkg::OP_POST: begin
          last_post_time <= spike_time;
          post_seen      <= 1'b1;
        end
        tsyn_pkg::OP_PAIR: begin
          last_pre_time  <= spike_time;
          last_post_time <= post_time;
          pre_seen       <= 1'b1;
          post_seen      <= 1'b1;
        end
        tsyn_pkg::OP_INIT: begin
          last_pre_time  <= '0;
          last_post_time <= '0;
          pre_seen       <= 1'b0;
          post_seen      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tsyn_fifo.sv =====
// Short command queue between the front end and the update engine.
module tsyn_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tsyn_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output tsyn_pkg::cmd_t rd_data,
  output logic           empty
);

  localparam int DEPTH = tsyn_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsyn_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/tsyn_back.sv =====
// Update engine: decay lookup, gain multiply, phase accumulation and hysteresis.
module tsyn_back #(
  parameter int DECAY_TABLE_DEPTH  = tsyn_pkg::DECAY_TABLE_DEPTH_DEF,
  parameter int TIME_FRACTION_BITS = tsyn_pkg::TIME_FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tsyn_pkg::cfg_t     cfg,
  input  tsyn_pkg::cmd_t     q_data,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [1:0]  ternary_weight,
  output logic signed [15:0] phase_value,
  output logic               updated
);

  localparam int IDX_W    = $clog2(DECAY_TABLE_DEPTH);
  localparam int ROM_SIZE = 1 << IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROM   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  logic [16:0]        rom [ROM_SIZE];
  logic [IDX_W-1:0]   k_idx;
  logic               far;
  logic               pos;
  logic [15:0]        remaining;
  logic [16:0]        decay;
  logic signed [15:0] delta;
  logic signed [15:0] phase;
  logic [1:0]         weight;
  logic               did;
  logic               out_valid;
  logic               load_out;

  logic [32:0]        mag;
  logic [31:0]        k_full;
  logic [33:0]        prod;
  logic [14:0]        mag_d;
  logic signed [16:0] sum;
  logic signed [15:0] p_new;
  logic [1:0]         w_new;
  logic signed [15:0] init_p;
  logic [1:0]         init_w;

  for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
    assign rom[g] = tsyn_pkg::decay_entry(g, DECAY_TABLE_DEPTH);
  end

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign load_out = (state == S_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    mag    = q_data.dt[32] ? 33'(-q_data.dt) : 33'(q_data.dt);
    k_full = 32'(mag >> TIME_FRACTION_BITS);
    prod   = 34'(pos ? cfg.pot_gain : cfg.dep_gain) * 34'(decay) + 34'(1 << 17);
    mag_d  = prod[32:18];

    sum = 17'(phase) + 17'(delta);
    if (sum > 17'(tsyn_pkg::PHASE_MAX))      p_new = tsyn_pkg::PHASE_MAX;
    else if (sum < 17'(tsyn_pkg::PHASE_MIN)) p_new = tsyn_pkg::PHASE_MIN;
    else                                     p_new = sum[15:0];

    priority if (weight == tsyn_pkg::W_POS) begin
      if (p_new <= cfg.fall)        w_new = tsyn_pkg::W_NEG;
      else if (p_new < cfg.rel_pos) w_new = tsyn_pkg::W_ZERO;
      else                          w_new = tsyn_pkg::W_POS;
    end else if (weight == tsyn_pkg::W_NEG) begin
      if (p_new >= cfg.rise)        w_new = tsyn_pkg::W_POS;
      else if (p_new > cfg.rel_neg) w_new = tsyn_pkg::W_ZERO;
      else                          w_new = tsyn_pkg::W_NEG;
    end else begin
      if (p_new >= cfg.rise)        w_new = tsyn_pkg::W_POS;
      else if (p_new <= cfg.fall)   w_new = tsyn_pkg::W_NEG;
      else                          w_new = tsyn_pkg::W_ZERO;
    end

    if (q_data.start > tsyn_pkg::PHASE_MAX)      init_p = tsyn_pkg::PHASE_MAX;
    else if (q_data.start < tsyn_pkg::PHASE_MIN) init_p = tsyn_pkg::PHASE_MIN;
    else                                         init_p = q_data.start;

    if (q_data.start > tsyn_pkg::INIT_HALF)       init_w = tsyn_pkg::W_POS;
    else if (q_data.start < -tsyn_pkg::INIT_HALF) init_w = tsyn_pkg::W_NEG;
    else                                          init_w = tsyn_pkg::W_ZERO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      weight    <= tsyn_pkg::W_ZERO;
      did       <= 1'b0;
      remaining <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            did <= 1'b0;
            unique case (q_data.kind)
              tsyn_pkg::KIND_UPDATE: state <= S_ROM;
              tsyn_pkg::KIND_INIT: begin
                phase  <= init_p;
                weight <= init_w;
                state  <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
            remaining <= q_data.count;
          end
        end
        S_ROM:   state <= S_MUL;
        S_MUL:   state <= S_APPLY;
        S_APPLY: begin
          phase     <= p_new;
          weight    <= w_new;
          did       <= 1'b1;
          remaining <= remaining - 1'b1;
          if (remaining == 16'd1) state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath stages of one update
  always_ff @(posedge clk) begin
    if (q_pop) begin
      k_idx <= k_full[IDX_W-1:0];
      far   <= (k_full >= 32'(DECAY_TABLE_DEPTH));
      pos   <= !q_data.dt[32] && (q_data.dt != '0);
    end
    if (state == S_ROM) decay <= far ? 17'd0 : rom[k_idx];
    if (state == S_MUL) delta <= pos ? $signed({1'b0, mag_d}) : -$signed({1'b0, mag_d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ternary_weight <= weight;
      phase_value    <= phase;
      updated        <= did;
    end
  end

endmodule
